FILE: hdl/pse_pkg.sv
// Shared constants, codes and the lane control struct for the parent selection engine.
// No dependencies; every other file but pse_ram imports this package.
package pse_pkg;

  localparam int MAX_POP    = 64;
  localparam int WEIGHT_W   = 32;
  localparam int POP_IDX_W  = $clog2(MAX_POP);
  localparam int CNT_W      = $clog2(MAX_POP + 1);
  localparam int CUM_W      = WEIGHT_W + POP_IDX_W;
  localparam int FRAC_W     = 32;
  localparam int PROD_W     = 2 * FRAC_W;
  localparam int HI_W       = CUM_W - FRAC_W;
  localparam int TGT_LO_W   = FRAC_W + 1;
  localparam int TGT_W      = CUM_W + 1;
  localparam int EQUAL_WEIGHT = 100;

  // Fixed field widths
  localparam int OP_W       = 2;
  localparam int IN_W       = 32;
  localparam int IDX_OUT_W  = 6;
  localparam int MODE_W     = 2;
  localparam int POP_CFG_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int POP_RESET  = 10;
  localparam int LEFT_RESET = (POP_RESET > MAX_POP) ? MAX_POP : POP_RESET;

  localparam logic [OP_W-1:0] OP_NEW_GEN = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EQUAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNIFORM  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_COUNT   = 1'd1;

  typedef enum logic [1:0] {
    MUL_LO,
    MUL_HI,
    MUL_LEFT
  } mul_sel_t;

  typedef struct packed {
    logic     start;
    logic     new_gen;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     tgt_lo_en;
    logic     tgt_en;
    logic     scan_clear;
    logic     cmp_valid;
    logic     rd_idx;
    logic     rd_last;
    logic     capture_pick;
    logic     wr_idx;
    logic     wr_last;
  } lane_ctrl_t;

endpackage

FILE: hdl/pse_in_if.sv
// Input channel: valid/ready handshake carrying one command item.
// Depends on pse_pkg for field widths.
interface pse_in_if;
  import pse_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IN_W-1:0]     weight;
  logic [IN_W-1:0]     rand_mother;
  logic [IN_W-1:0]     rand_father;

  modport source (output valid, op, weight, rand_mother, rand_father, input ready);
  modport sink   (input valid, op, weight, rand_mother, rand_father, output ready);
endinterface

FILE: hdl/pse_out_if.sv
// Output channel: valid/ready handshake carrying one selection result.
// Depends on pse_pkg for field widths.
interface pse_out_if;
  import pse_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] mother_index;
  logic [IDX_OUT_W-1:0] father_index;
  logic                 error;

  modport source (output valid, mother_index, father_index, error, input ready);
  modport sink   (input valid, mother_index, father_index, error, output ready);
endinterface

FILE: hdl/pse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/pse_lane.sv
// One selection lane: target multiply, wheel compare and its own parent pool.
// Depends on pse_pkg and pse_ram.
module pse_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  pse_pkg::lane_ctrl_t             ctrl,
  input  logic [pse_pkg::FRAC_W-1:0]      frac,
  input  logic [pse_pkg::CUM_W-1:0]       total,
  input  logic [pse_pkg::CNT_W-1:0]       active_pop,
  input  logic [pse_pkg::POP_IDX_W-1:0]   last_index,
  input  logic [pse_pkg::CUM_W-1:0]       cmp_val,
  input  logic [pse_pkg::POP_IDX_W-1:0]   cmp_j,
  output logic [pse_pkg::POP_IDX_W-1:0]   pick,
  output logic                            empty
);
  import pse_pkg::*;

  logic [FRAC_W-1:0]    frac_q;
  logic [PROD_W-1:0]    prod_q;
  logic [TGT_LO_W-1:0]  tgt_lo_q;
  logic [TGT_W-1:0]     target_q;
  logic                 found_q;
  logic [POP_IDX_W-1:0] pick_q;
  logic [CNT_W-1:0]     left_q;
  logic [MAX_POP-1:0]   pool_valid_q;

  logic [FRAC_W-1:0]    mul_opnd;
  logic [POP_IDX_W-1:0] idx;
  logic [POP_IDX_W-1:0] last_pos;
  logic [POP_IDX_W-1:0] pool_rd_data;
  logic [POP_IDX_W-1:0] entry_idx;
  logic [POP_IDX_W-1:0] entry_last;
  logic                 hit;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_LO:   mul_opnd = total[FRAC_W-1:0];
      MUL_HI:   mul_opnd = FRAC_W'(total[CUM_W-1:FRAC_W]);
      MUL_LEFT: mul_opnd = FRAC_W'(left_q);
      default:  mul_opnd = '0;
    endcase
  end

  // floor(frac * left / 2^32) sits just above the fraction bits
  assign idx        = prod_q[FRAC_W +: POP_IDX_W];
  assign last_pos   = POP_IDX_W'(left_q - 1'b1);
  // untouched pool entries hold their own index
  assign entry_idx  = pool_valid_q[idx] ? pool_rd_data : idx;
  assign entry_last = pool_valid_q[last_pos] ? pool_rd_data : last_pos;
  assign hit        = ctrl.cmp_valid && !found_q && ({1'b0, cmp_val} >= target_q);
  assign pick       = pick_q;
  assign empty      = (left_q == '0);

  pse_ram #(
    .WIDTH (POP_IDX_W),
    .DEPTH (MAX_POP)
  ) u_pool_ram (
    .clk     (clk),
    .wr_en   (ctrl.wr_idx | ctrl.wr_last),
    .wr_addr (ctrl.wr_idx ? idx : last_pos),
    .wr_data (ctrl.wr_idx ? entry_last : pick_q),
    .rd_en   (ctrl.rd_idx | ctrl.rd_last),
    .rd_addr (ctrl.rd_idx ? idx : last_pos),
    .rd_data (pool_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      found_q      <= 1'b0;
      left_q       <= CNT_W'(LEFT_RESET);
      pool_valid_q <= '0;
    end else begin
      if (ctrl.new_gen) begin
        left_q       <= active_pop;
        pool_valid_q <= '0;
      end
      if (ctrl.scan_clear) begin
        found_q <= 1'b0;
      end else if (hit) begin
        found_q <= 1'b1;
      end
      if (ctrl.wr_idx) begin
        pool_valid_q[idx] <= 1'b1;
      end
      if (ctrl.wr_last) begin
        pool_valid_q[last_pos] <= 1'b1;
        left_q                 <= left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      frac_q <= frac;
    end
    if (ctrl.mul_en) begin
      prod_q <= PROD_W'(frac_q) * PROD_W'(mul_opnd);
    end
    // low partial product rounded up: ceiling of the exact scaled value
    if (ctrl.tgt_lo_en) begin
      tgt_lo_q <= TGT_LO_W'(prod_q[PROD_W-1:FRAC_W]) + TGT_LO_W'(|prod_q[FRAC_W-1:0]);
    end
    if (ctrl.tgt_en) begin
      target_q <= TGT_W'(prod_q[CUM_W-1:0]) + TGT_W'(tgt_lo_q);
    end
    if (ctrl.scan_clear) begin
      pick_q <= last_index;
    end else if (hit) begin
      pick_q <= cmp_j;
    end else if (ctrl.capture_pick) begin
      pick_q <= entry_idx;
    end
  end

endmodule

FILE: hdl/pse_merge.sv
// Merge stage and output register: combines both lane picks with the error flag.
// Depends on pse_pkg and pse_out_if.
module pse_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          draw_ok,
  input  logic                          err,
  input  logic [pse_pkg::POP_IDX_W-1:0] mother_pick,
  input  logic [pse_pkg::POP_IDX_W-1:0] father_pick,
  output logic                          free,
  pse_out_if.source                     out_ch
);
  import pse_pkg::*;

  logic                 valid_q;
  logic [IDX_OUT_W-1:0] mother_q;
  logic [IDX_OUT_W-1:0] father_q;
  logic                 err_q;

  assign free                = !valid_q || out_ch.ready;
  assign out_ch.valid        = valid_q;
  assign out_ch.mother_index = mother_q;
  assign out_ch.father_index = father_q;
  assign out_ch.error        = err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mother_q <= draw_ok ? IDX_OUT_W'(mother_pick) : '0;
      father_q <= draw_ok ? IDX_OUT_W'(father_pick) : '0;
      err_q    <= err;
    end
  end

endmodule

FILE: hdl/parent_selection_engine_core.sv
// Roulette-wheel parent selection, top level: command sequencer, cumulative table, two lanes.
// Weighted and equal draws scan the wheel one cumulative-table read per cycle, at most 64 entries;
// new generation, load and error items and uniform draws skip the scan.
// Items are taken one at a time; the output register lets the next item in while it waits.
// Reset (synchronous, rst high): mode equal, population 10, table empty, pools identity.
// Depends on pse_pkg, pse_in_if, pse_out_if, pse_ram, pse_lane, pse_merge.
module parent_selection_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data,
  pse_in_if.sink                         in_ch,
  pse_out_if.source                      out_ch
);
  import pse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_TGT,
    S_SCAN,
    S_TAIL,
    S_U_MUL,
    S_U_RDA,
    S_U_RDB,
    S_U_WRA,
    S_U_WRB,
    S_DONE
  } state_t;

  // Registers
  state_t               state, state_next;
  logic [MODE_W-1:0]    select_mode;
  logic [POP_CFG_W-1:0] population_count;
  logic [CNT_W-1:0]     loaded_count, loaded_count_next;
  logic [CUM_W-1:0]     total, total_next;
  logic [CUM_W-1:0]     wheel_total, wheel_total_next;
  logic [POP_IDX_W-1:0] count_last, count_last_next;
  logic                 equal_mode, equal_mode_next;
  logic [POP_IDX_W-1:0] scan_idx, scan_idx_next;
  logic                 cmp_valid;
  logic [POP_IDX_W-1:0] cmp_j;
  logic                 draw_ok, draw_ok_next;
  logic                 res_err, res_err_next;

  // Combinational
  logic                 accept;
  logic [CNT_W-1:0]     active_pop;
  logic [CUM_W-1:0]     equal_total;
  logic [CUM_W-1:0]     cum_rd_data;
  logic [CUM_W-1:0]     cmp_val;
  logic                 load_full;
  logic                 load_write;
  logic                 is_uniform;
  logic                 mother_empty;
  logic                 father_empty;
  logic [POP_IDX_W-1:0] mother_pick;
  logic [POP_IDX_W-1:0] father_pick;
  logic                 merge_free;
  logic                 merge_load;
  lane_ctrl_t           lane_ctrl;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Population 0 acts as 1, anything above the table depth as the depth
  always_comb begin
    if (population_count == '0) begin
      active_pop = CNT_W'(1);
    end else if (int'(population_count) > MAX_POP) begin
      active_pop = CNT_W'(MAX_POP);
    end else begin
      active_pop = CNT_W'(population_count);
    end
  end

  assign equal_total = CUM_W'(active_pop * EQUAL_WEIGHT);
  assign load_full   = (loaded_count >= active_pop);
  assign load_write  = accept && (in_ch.op == OP_LOAD) && !load_full;
  // the spare mode code behaves as uniform
  assign is_uniform  = (select_mode != MODE_WEIGHTED) && (select_mode != MODE_EQUAL);

  // Equal mode makes up the wheel on the fly: entry j sums to 100 * (j + 1)
  assign cmp_val = equal_mode ? CUM_W'(({1'b0, cmp_j} + 1'b1) * EQUAL_WEIGHT) : cum_rd_data;

  // Cumulative table: written on a load transfer that the table has room for, read once per scan cycle
  pse_ram #(
    .WIDTH (CUM_W),
    .DEPTH (MAX_POP)
  ) u_cum_ram (
    .clk     (clk),
    .wr_en   (load_write),
    .wr_addr (loaded_count[POP_IDX_W-1:0]),
    .wr_data (total + CUM_W'(in_ch.weight[WEIGHT_W-1:0])),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_idx),
    .rd_data (cum_rd_data)
  );

  // Sequencer: next state and per-item bookkeeping
  always_comb begin
    state_next        = state;
    loaded_count_next = loaded_count;
    total_next        = total;
    wheel_total_next  = wheel_total;
    count_last_next   = count_last;
    equal_mode_next   = equal_mode;
    scan_idx_next     = scan_idx;
    draw_ok_next      = draw_ok;
    res_err_next      = res_err;
    merge_load        = 1'b0;
    lane_ctrl         = '0;
    lane_ctrl.cmp_valid = cmp_valid;

    case (state)
      S_IDLE: begin
        lane_ctrl.start = accept;
        if (accept) begin
          draw_ok_next = 1'b0;
          res_err_next = 1'b0;
          state_next   = S_DONE;
          case (in_ch.op)
            OP_NEW_GEN: begin
              lane_ctrl.new_gen = 1'b1;
              loaded_count_next = '0;
              total_next        = '0;
            end
            OP_LOAD: begin
              if (load_full) begin
                res_err_next = 1'b1;
              end else begin
                loaded_count_next = loaded_count + 1'b1;
                total_next        = total + CUM_W'(in_ch.weight[WEIGHT_W-1:0]);
              end
            end
            OP_DRAW: begin
              if (is_uniform) begin
                if (mother_empty || father_empty) begin
                  res_err_next = 1'b1;
                end else begin
                  draw_ok_next = 1'b1;
                  state_next   = S_U_MUL;
                end
              end else if (select_mode == MODE_EQUAL) begin
                draw_ok_next     = 1'b1;
                equal_mode_next  = 1'b1;
                wheel_total_next = equal_total;
                count_last_next  = POP_IDX_W'(active_pop - 1'b1);
                state_next       = S_MUL_LO;
              end else if (loaded_count == '0) begin
                res_err_next = 1'b1;
              end else begin
                // weighted search covers every loaded entry
                draw_ok_next     = 1'b1;
                equal_mode_next  = 1'b0;
                wheel_total_next = total;
                count_last_next  = POP_IDX_W'(loaded_count - 1'b1);
                state_next       = S_MUL_LO;
              end
            end
            default: begin
              // unused op: all fields zero, no table or pool change
            end
          endcase
        end
      end
      S_MUL_LO: begin
        lane_ctrl.mul_en  = 1'b1;
        lane_ctrl.mul_sel = MUL_LO;
        state_next        = S_MUL_HI;
      end
      S_MUL_HI: begin
        lane_ctrl.mul_en    = 1'b1;
        lane_ctrl.mul_sel   = MUL_HI;
        lane_ctrl.tgt_lo_en = 1'b1;
        state_next          = S_TGT;
      end
      S_TGT: begin
        lane_ctrl.tgt_en     = 1'b1;
        lane_ctrl.scan_clear = 1'b1;
        scan_idx_next        = '0;
        state_next           = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx == count_last) begin
          state_next = S_TAIL;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      S_TAIL: begin
        // last read data compared this cycle
        state_next = S_DONE;
      end
      S_U_MUL: begin
        lane_ctrl.mul_en  = 1'b1;
        lane_ctrl.mul_sel = MUL_LEFT;
        state_next        = S_U_RDA;
      end
      S_U_RDA: begin
        lane_ctrl.rd_idx = 1'b1;
        state_next       = S_U_RDB;
      end
      S_U_RDB: begin
        lane_ctrl.rd_last      = 1'b1;
        lane_ctrl.capture_pick = 1'b1;
        state_next             = S_U_WRA;
      end
      S_U_WRA: begin
        lane_ctrl.wr_idx = 1'b1;
        state_next       = S_U_WRB;
      end
      S_U_WRB: begin
        lane_ctrl.wr_last = 1'b1;
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      select_mode      <= MODE_EQUAL;
      population_count <= POP_CFG_W'(POP_RESET);
      loaded_count     <= '0;
      total            <= '0;
      cmp_valid        <= 1'b0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      total        <= total_next;
      cmp_valid    <= (state == S_SCAN);
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_SELECT_MODE: select_mode      <= cfg_data[MODE_W-1:0];
          CFG_POP_COUNT:   population_count <= cfg_data[POP_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    wheel_total <= wheel_total_next;
    count_last  <= count_last_next;
    equal_mode  <= equal_mode_next;
    scan_idx    <= scan_idx_next;
    cmp_j       <= scan_idx;
    draw_ok     <= draw_ok_next;
    res_err     <= res_err_next;
  end

  // Two lanes, one per parent, sharing the wheel read
  pse_lane u_mother_lane (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .frac       (in_ch.rand_mother),
    .total      (wheel_total),
    .active_pop (active_pop),
    .last_index (count_last),
    .cmp_val    (cmp_val),
    .cmp_j      (cmp_j),
    .pick       (mother_pick),
    .empty      (mother_empty)
  );

  pse_lane u_father_lane (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .frac       (in_ch.rand_father),
    .total      (wheel_total),
    .active_pop (active_pop),
    .last_index (count_last),
    .cmp_val    (cmp_val),
    .cmp_j      (cmp_j),
    .pick       (father_pick),
    .empty      (father_empty)
  );

  pse_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (merge_load),
    .draw_ok     (draw_ok),
    .err         (res_err),
    .mother_pick (mother_pick),
    .father_pick (father_pick),
    .free        (merge_free),
    .out_ch      (out_ch)
  );

  // Compare strobes only ever follow a scan read
  assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN || state == S_TAIL))
    else $error("wheel compare outside a scan");

  // A load into a full table leaves the fill count alone
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.op == OP_LOAD && load_full) |=> $stable(loaded_count))
    else $error("rejected load changed the table fill");

  // An error result never carries indices
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.error) |-> (out_ch.mother_index == '0 && out_ch.father_index == '0))
    else $error("error result with non-zero indices");

endmodule

FILE: bench/parent_selection_engine_core_tb.sv
// Testbench for parent_selection_engine_core: random and directed command transfers,
// a behavioural mirror of the roulette and pool selection rules, in-order result checks.
// Depends on pse_pkg, pse_in_if, pse_out_if and the core RTL.
module parent_selection_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_GAP    = 8;     // every item gives a result, so a short pause will do
  localparam int TAIL_GAP     = 80;    // covers the longest draw, a scan of 64 entries
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_CAP   = 30;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [IN_W-1:0] weight;
    logic [IN_W-1:0] rand_mother;
    logic [IN_W-1:0] rand_father;
  } cmd_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] mother;
    logic [IDX_OUT_W-1:0] father;
    logic                 error;
  } pick_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pse_in_if  in_ch();
  pse_out_if out_ch();

  parent_selection_engine_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioural mirror of the selection engine
  // ---------------------------------------------------------------------------
  logic [CUM_W-1:0]     cum_table [MAX_POP];  // running weight sums, one per loaded entry
  int unsigned          loaded;
  logic [POP_IDX_W-1:0] pool [2][MAX_POP];    // [0] mothers, [1] fathers
  int unsigned          pool_left [2];
  logic [MODE_W-1:0]    sel_mode;
  logic [POP_CFG_W-1:0] pop_reg;

  pick_t       pending_picks [$];            // predicted results, oldest first
  int unsigned failures      = 0;
  int unsigned issued        = 0;            // transfers that the block acts on
  int unsigned op_count [4]  = '{0, 0, 0, 0};
  int unsigned mode_draws [4] = '{0, 0, 0, 0};
  int unsigned results_seen  = 0;
  int unsigned error_results = 0;
  int unsigned cycles        = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_len  = 0;
  int          hold_seq  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // population register clamped to 1..MAX_POP
  function automatic int unsigned live_pop();
    if (pop_reg == 0) return 1;
    if (pop_reg > MAX_POP) return MAX_POP;
    return pop_reg;
  endfunction

  function automatic void start_generation();
    loaded = 0;
    for (int i = 0; i < MAX_POP; i++) begin
      pool[0][i] = POP_IDX_W'(i);
      pool[1][i] = POP_IDX_W'(i);
    end
    pool_left[0] = live_pop();
    pool_left[1] = pool_left[0];
  endfunction

  function automatic logic [CUM_W-1:0] cum_at(bit equal, int unsigned j);
    if (equal) return CUM_W'(EQUAL_WEIGHT * (j + 1));
    return cum_table[j];
  endfunction

  // first entry whose sum reaches ceil(frac * total / 2^32), else the last entry
  function automatic int unsigned spin_wheel(bit equal, int unsigned count,
                                             logic [FRAC_W-1:0] frac);
    logic [CUM_W+FRAC_W-1:0] prod;
    logic [CUM_W:0]          target;
    prod   = cum_at(equal, count - 1) * frac;
    target = prod[CUM_W+FRAC_W-1:FRAC_W] + (prod[FRAC_W-1:0] != '0);
    for (int unsigned j = 0; j < count; j++)
      if ({1'b0, cum_at(equal, j)} >= target) return j;
    return count - 1;
  endfunction

  // take floor(frac * left) from the pool, swap it to the end and shrink the pool
  function automatic int unsigned pool_take(int side, logic [FRAC_W-1:0] frac);
    logic [FRAC_W+CNT_W-1:0] prod;
    int unsigned             n;
    int unsigned             slot;
    logic [POP_IDX_W-1:0]    chosen;
    n      = pool_left[side];
    prod   = frac * CNT_W'(n);
    slot   = prod[FRAC_W+CNT_W-1:FRAC_W];
    chosen = pool[side][slot];
    pool[side][slot]  = pool[side][n - 1];
    pool[side][n - 1] = chosen;
    pool_left[side]   = n - 1;
    return chosen;
  endfunction

  function automatic pick_t select_parents(cmd_t c);
    pick_t            p;
    logic [CUM_W-1:0] prev;
    p = '0;
    case (c.op)
      OP_NEW_GEN: start_generation();
      OP_LOAD: begin
        // table full for this population: flagged and dropped
        if (loaded >= live_pop() || loaded >= MAX_POP) begin
          p.error = 1'b1;
        end else begin
          prev = (loaded == 0) ? '0 : cum_table[loaded - 1];
          cum_table[loaded] = prev + c.weight;
          loaded++;
        end
      end
      OP_DRAW: begin
        if (sel_mode == MODE_WEIGHTED) begin
          // searches every loaded entry, whatever the population register says
          if (loaded == 0) begin
            p.error = 1'b1;
          end else begin
            p.mother = IDX_OUT_W'(spin_wheel(1'b0, loaded, c.rand_mother));
            p.father = IDX_OUT_W'(spin_wheel(1'b0, loaded, c.rand_father));
          end
        end else if (sel_mode == MODE_EQUAL) begin
          p.mother = IDX_OUT_W'(spin_wheel(1'b1, live_pop(), c.rand_mother));
          p.father = IDX_OUT_W'(spin_wheel(1'b1, live_pop(), c.rand_father));
        end else if (pool_left[0] == 0 || pool_left[1] == 0) begin
          // uniform (and the spare mode) with a pool run dry: no pool change
          p.error = 1'b1;
        end else begin
          p.mother = IDX_OUT_W'(pool_take(0, c.rand_mother));
          p.father = IDX_OUT_W'(pool_take(1, c.rand_father));
        end
      end
      default: ;  // spare op: nothing changes, all zero
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call, prediction taken at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [OP_W-1:0] op, logic [IN_W-1:0] weight,
                           logic [IN_W-1:0] rand_mother, logic [IN_W-1:0] rand_father);
    cmd_t c;
    c = '{op, weight, rand_mother, rand_father};
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    // valid is never dropped between back-to-back transfers, only re-driven high
    in_ch.valid       <= 1'b1;
    in_ch.op          <= c.op;
    in_ch.weight      <= c.weight;
    in_ch.rand_mother <= c.rand_mother;
    in_ch.rand_father <= c.rand_father;
    do @(posedge clk); while (!in_ch.ready);
    if (c.op == OP_DRAW) mode_draws[sel_mode]++;
    op_count[c.op]++;
    if (c.op != OP_SPARE) issued++;
    pending_picks.push_back(select_parents(c));
  endtask

  // let every outstanding result come back with the input idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == CFG_SELECT_MODE) sel_mode = data[MODE_W-1:0];
    else pop_reg = data;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern with an optional long hold-off, and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  pick_t want_pick;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.error) error_results++;
      if (pending_picks.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual mother %0d father %0d error %0b",
                   $time, out_ch.mother_index, out_ch.father_index, out_ch.error);
      end else begin
        want_pick = pending_picks.pop_front();
        check_field("mother_index", want_pick.mother, out_ch.mother_index);
        check_field("father_index", want_pick.father, out_ch.father_index);
        check_field("error", want_pick.error, out_ch.error);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [IN_W-1:0] rand_fraction();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return IN_W'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  // odd transfer now and then: spare op, stray new generation, load or draw out of order
  task automatic maybe_noise();
    if ($urandom_range(9) == 0)
      send_item(OP_W'($urandom_range(3)), $urandom, rand_fraction(), rand_fraction());
  endtask

  // mostly small populations, the odd extreme
  task automatic randomise_config();
    logic [CFG_DATA_W-1:0] mode_val;
    logic [CFG_DATA_W-1:0] pop_val;
    mode_val = CFG_DATA_W'($urandom);    // bits above the mode field are don't-care
    mode_val[MODE_W-1:0] = MODE_W'($urandom_range(3));
    case ($urandom_range(9))
      0:       pop_val = '0;
      1:       pop_val = CFG_DATA_W'(MAX_POP);
      2:       pop_val = CFG_DATA_W'($urandom_range(MAX_POP + 1, 127));
      3:       pop_val = CFG_DATA_W'($urandom_range(13, MAX_POP));
      default: pop_val = CFG_DATA_W'($urandom_range(1, 12));
    endcase
    write_reg(CFG_SELECT_MODE, mode_val);
    write_reg(CFG_POP_COUNT, pop_val);
  endtask

  // a generation: new generation, a table of loads, a run of draws, with some noise
  task automatic run_generation();
    int unsigned n_loads;
    int unsigned n_draws;
    if ($urandom_range(9) != 0) send_item(OP_NEW_GEN, $urandom, $urandom, $urandom);
    n_loads = ($urandom_range(1) == 0) ? live_pop() : $urandom_range(live_pop() + 2);
    n_draws = $urandom_range(1, (live_pop() > 22) ? 24 : live_pop() + 2);
    repeat (n_loads) begin
      maybe_noise();
      send_item(OP_LOAD, rand_weight(), $urandom, $urandom);
    end
    repeat (n_draws) begin
      maybe_noise();
      send_item(OP_DRAW, $urandom, rand_fraction(), rand_fraction());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset state: equal weights over ten entries; fraction extremes, exact boundary, spare op
  task automatic test_equal_mode();
    send_item(OP_DRAW, '0, '0, '1);
    send_item(OP_DRAW, '1, 32'h8000_0000, 32'h8000_0001);
    send_item(OP_SPARE, '1, '1, '1);
  endtask

  // weighted: empty table, zero and full-scale weights, boundary hit exactly and just past
  task automatic test_weighted_mode();
    write_reg(CFG_SELECT_MODE, CFG_DATA_W'(MODE_WEIGHTED));
    send_item(OP_DRAW, '0, $urandom, $urandom);
    send_item(OP_NEW_GEN, '0, '0, '0);
    send_item(OP_LOAD, '0, '0, '0);
    send_item(OP_LOAD, '1, '0, '0);
    send_item(OP_LOAD, 32'h100, '0, '0);
    send_item(OP_DRAW, '0, '0, '1);
    send_item(OP_NEW_GEN, '0, '0, '0);
    send_item(OP_LOAD, 32'd1, '0, '0);
    send_item(OP_LOAD, 32'd1, '0, '0);
    send_item(OP_DRAW, '0, 32'h8000_0000, 32'h8000_0001);
  endtask

  // loads past the population are refused; population zero behaves as one
  task automatic test_table_full();
    write_reg(CFG_POP_COUNT, CFG_DATA_W'(2));
    send_item(OP_NEW_GEN, '1, '1, '1);
    repeat (3) send_item(OP_LOAD, $urandom, '0, '0);
    write_reg(CFG_POP_COUNT, '0);
    send_item(OP_NEW_GEN, '0, '0, '0);
    repeat (2) send_item(OP_LOAD, $urandom, '0, '0);
  endtask

  // uniform pools: oversize population clamps, spare mode acts uniform, empty pool flagged
  task automatic test_uniform_mode();
    write_reg(CFG_SELECT_MODE, {{(CFG_DATA_W - MODE_W){1'b1}}, MODE_UNIFORM});
    write_reg(CFG_POP_COUNT, '1);
    send_item(OP_NEW_GEN, '0, '0, '0);
    send_item(OP_DRAW, '0, '1, '0);
    send_item(OP_DRAW, '0, '1, '1);
    write_reg(CFG_SELECT_MODE, CFG_DATA_W'(MODE_SPARE));
    write_reg(CFG_POP_COUNT, CFG_DATA_W'(1));
    send_item(OP_NEW_GEN, '0, '0, '0);
    send_item(OP_DRAW, '0, '1, '1);
    send_item(OP_DRAW, '0, $urandom, $urandom);
  endtask

  // random generations under four idle patterns, a quarter of the items each
  task automatic test_random_phases();
    int unsigned goal;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      goal = issued + RANDOM_ITEMS / 4;
      while (issued < goal) begin
        if ($urandom_range(1) == 0) randomise_config();
        run_generation();
      end
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering transfers,
  // so the output register and then the input side stall
  task automatic test_backpressure();
    write_reg(CFG_SELECT_MODE, CFG_DATA_W'(MODE_UNIFORM));
    write_reg(CFG_POP_COUNT, CFG_DATA_W'(MAX_POP));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_NEW_GEN, '0, '0, '0);
    hold_len <= HOLD_CYCLES;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2) send_item(OP_LOAD, rand_weight(), '0, '0);
      else send_item(OP_DRAW, '0, $urandom, $urandom);
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_write_en      <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= '0;
    in_ch.weight      <= '0;
    in_ch.rand_mother <= '0;
    in_ch.rand_father <= '0;
    sel_mode = MODE_EQUAL;
    pop_reg  = POP_CFG_W'(POP_RESET);
    start_generation();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_equal_mode();
    test_weighted_mode();
    test_table_full();
    test_uniform_mode();
    test_random_phases();
    test_backpressure();

    drain();
    repeat (TAIL_GAP) @(posedge clk);
    if (pending_picks.size() != 0) begin
      failures++;
      $display("%0t: %0d results never arrived", $time, pending_picks.size());
    end

    $display("summary: %0d transfers in (%0d new generation, %0d load, %0d draw, %0d spare op),",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("summary: draws weighted %0d equal %0d uniform %0d spare-mode %0d, %0d/%0d error results",
             mode_draws[0], mode_draws[1], mode_draws[2], mode_draws[3],
             error_results, results_seen);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
